// ===== src/fixed_block_free_list_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// fixed block free list allocator: assertion macros
// clocked assertion helpers, empty when synthesising
// ---------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FBFL_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FBFL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define FBFL_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define FBFL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/fbfl_pkg.sv =====
// ---------------------------------------------------------------------------
// fbfl_pkg
// shared types and codes of the fixed block free list allocator
// ---------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int SIZE_W     = 13;
  localparam int OFFSET_W   = 20;
  localparam int BYTES_W    = 21;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_BLOCK = 1'b1;

  localparam logic [8:0]        RESET_BLOCKS    = 9'd256;
  localparam logic [SIZE_W-1:0] RESET_BYTES     = 13'd64;
  localparam logic [SIZE_W-1:0] MIN_BLOCK_BYTES = 13'd8;
  localparam logic [SIZE_W-1:0] MAX_BLOCK_BYTES = 13'd4096;

  localparam logic [1:0] FN_ALLOC      = 2'd0;
  localparam logic [1:0] FN_RELEASE    = 2'd1;
  localparam logic [1:0] FN_POOL_RESET = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_NULL       = 3'd2,
    ST_BAD_INDEX  = 3'd3,
    ST_NONE_ALLOC = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_SWEEP
  } state_t;

  typedef struct packed {
    logic [1:0] func;
    logic       has_block;
    logic [7:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [7:0]          granted_index;
    logic [OFFSET_W-1:0] granted_offset;
    logic [8:0]          used_blocks;
    logic [8:0]          free_blocks;
    logic [BYTES_W-1:0]  used_bytes;
    logic [BYTES_W-1:0]  capacity_bytes;
  } out_item_t;

  // what the control side hands to the result stage
  typedef struct packed {
    logic                load;
    status_t             status;
    logic [OFFSET_W-1:0] g_idx;
    logic [BYTES_W-1:0]  count;
    logic [BYTES_W-1:0]  alloc;
  } fbfl_req_t;

endpackage

`default_nettype wire

// ===== src/fbfl_result_reg.sv =====
// ---------------------------------------------------------------------------
// fbfl_result_reg
// scales counts by the block size and registers the result item
// ---------------------------------------------------------------------------
`default_nettype none

module fbfl_result_reg
  import fbfl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fbfl_req_t         req,
  input  wire logic [SIZE_W-1:0] size,
  output logic                   done,
  output out_item_t              result
);

  logic [OFFSET_W+SIZE_W-1:0] off_prod;
  logic [BYTES_W+SIZE_W-1:0]  used_prod;
  logic [BYTES_W+SIZE_W-1:0]  cap_prod;

  assign off_prod  = (OFFSET_W+SIZE_W)'(req.g_idx) * (OFFSET_W+SIZE_W)'(size);
  assign used_prod = (BYTES_W+SIZE_W)'(req.alloc) * (BYTES_W+SIZE_W)'(size);
  assign cap_prod  = (BYTES_W+SIZE_W)'(req.count) * (BYTES_W+SIZE_W)'(size);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req.load;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      result.status         <= req.status;
      result.granted_index  <= req.g_idx[7:0];
      result.granted_offset <= off_prod[OFFSET_W-1:0];
      result.used_blocks    <= req.alloc[8:0];
      result.free_blocks    <= 9'(req.count - req.alloc);
      result.used_bytes     <= used_prod[BYTES_W-1:0];
      result.capacity_bytes <= cap_prod[BYTES_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/fixed_block_free_list_allocator.sv =====
// ---------------------------------------------------------------------------
// fixed_block_free_list_allocator
// pool of equal blocks kept as a last-in first-out free list in a link ram
// ---------------------------------------------------------------------------
// usage
//   request: an item is taken at a clock edge where start is high and busy
//   is low. func selects allocate, release or pool reset.
//   result: one item per request, on result for one cycle with done high,
//   the cycle after the request is taken. there is no back-pressure.
//   cfg: cfg_we writes blocks_in_use (index 0) or bytes_per_block (index 1)
//   at once; either write rebuilds the pool.
// timing
//   a granted allocate grants the head block at once, then waits in S_ALLOC
//   for the link ram read of its successor, which becomes the new head.
//   release, a refused allocate and the unused code stay in S_IDLE.
//   pool reset, a cfg write and rst each start a rebuild sweep that writes
//   one link per cycle, so busy stays high until all n links are written
//   (n = effective block count, 256 after rst with the default parameter).
// reset
//   rst restores the default registers, frees every block in the pool and
//   rebuilds the chain 0..n-1 in the link ram.
// ---------------------------------------------------------------------------
`default_nettype none

`include "fixed_block_free_list_allocator_macros.svh"

module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = 256
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              request,
  output logic                       done,
  output out_item_t                  result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // link and count width, null link is MAX_BLOCKS
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(MAX_BLOCKS);
  // compare width covering the 9 bit register and the links
  localparam int KW = (LW > 9) ? LW : 9;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);

  // configuration registers
  logic [8:0]        blocks_in_use;
  logic [SIZE_W-1:0] bytes_per_block;

  // control state
  state_t        state, state_next;
  logic [LW-1:0] head, head_next;
  logic [LW-1:0] alloc, alloc_next;
  logic [LW-1:0] ptr, ptr_next;
  logic [LW-1:0] ptr_inc;
  logic [LW-1:0] sweep_link;

  // effective block count and size
  logic [LW-1:0]     count;
  logic [KW-1:0]     bu_k;
  logic [SIZE_W-1:0] size;
  logic [KW-1:0]     idx_k;

  // link ram
  logic [LW-1:0] link_mem [MAX_BLOCKS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [LW-1:0] rd_data;

  fbfl_req_t req;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use   <= RESET_BLOCKS;
      bytes_per_block <= RESET_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCKS_IN_USE:   blocks_in_use   <= cfg_data[8:0];
        REG_BYTES_PER_BLOCK: bytes_per_block <= cfg_data;
        default: ;
      endcase
    end
  end

  // block count clamped to 1..MAX_BLOCKS, size clamped to 8..4096
  assign bu_k = KW'(blocks_in_use);

  always_comb begin
    if (blocks_in_use == 9'd0) begin
      count = LW'(1);
    end else if (bu_k > KW'(MAX_BLOCKS)) begin
      count = LW'(MAX_BLOCKS);
    end else begin
      count = LW'(bu_k);
    end
    if (bytes_per_block < MIN_BLOCK_BYTES) begin
      size = MIN_BLOCK_BYTES;
    end else if (bytes_per_block > MAX_BLOCK_BYTES) begin
      size = MAX_BLOCK_BYTES;
    end else begin
      size = bytes_per_block;
    end
  end

  assign idx_k      = KW'(request.block_index);
  assign ptr_inc    = LW'(ptr + 1'b1);
  // sweep rebuilds the chain: entry i links to i+1, the last one to null
  assign sweep_link = (ptr_inc < count) ? ptr_inc : NULL_LINK;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      head  <= '0;
      alloc <= '0;
      ptr   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      alloc <= alloc_next;
      ptr   <= ptr_next;
    end
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    alloc_next = alloc;
    ptr_next   = ptr;
    mem_we     = 1'b0;
    mem_waddr  = ptr[AW-1:0];
    mem_wdata  = sweep_link;
    req.load   = 1'b0;
    req.status = ST_OK;
    req.g_idx  = '0;
    req.count  = BYTES_W'(count);
    req.alloc  = BYTES_W'(alloc);
    busy       = (state != S_IDLE);

    case (state)
      S_IDLE: begin
        if (start) begin
          req.load = 1'b1;
          case (request.func)
            FN_ALLOC: begin
              if (head >= count || alloc >= count) begin
                req.status = ST_EMPTY;
              end else begin
                // grant the head now, its successor comes from the ram read
                req.g_idx  = OFFSET_W'(head);
                alloc_next = LW'(alloc + 1'b1);
                state_next = S_ALLOC;
              end
            end
            FN_RELEASE: begin
              if (!request.has_block) begin
                req.status = ST_NULL;
              end else if (idx_k >= KW'(count)) begin
                req.status = ST_BAD_INDEX;
              end else if (alloc == '0) begin
                req.status = ST_NONE_ALLOC;
              end else begin
                // push onto the head of the free list
                mem_we     = 1'b1;
                mem_waddr  = idx_k[AW-1:0];
                mem_wdata  = head;
                head_next  = idx_k[LW-1:0];
                alloc_next = LW'(alloc - 1'b1);
              end
            end
            FN_POOL_RESET: begin
              head_next  = '0;
              alloc_next = '0;
              ptr_next   = '0;
              state_next = S_SWEEP;
            end
            default: ;
          endcase
          req.alloc = BYTES_W'(alloc_next);
        end
      end
      S_ALLOC: begin
        head_next  = rd_data;
        state_next = S_IDLE;
      end
      S_SWEEP: begin
        mem_we   = 1'b1;
        ptr_next = ptr_inc;
        if (ptr_inc == count) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // a register write rebuilds the pool, restarting any sweep
    if (cfg_we) begin
      head_next  = '0;
      alloc_next = '0;
      ptr_next   = '0;
      state_next = S_SWEEP;
    end
  end

  // link ram, read of the head every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= link_mem[head[AW-1:0]];
  end

  fbfl_result_reg u_result (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .size   (size),
    .done   (done),
    .result (result)
  );

  // every taken request gives exactly one result on the next cycle
  `FBFL_ASSERT_CLK(a_done_after_take, clk, rst, (start && !busy) |=> done, "result missing")
  `FBFL_ASSERT_CLK(a_no_spare_done, clk, rst, !(start && !busy) |=> !done, "spurious result")
  // allocated count never passes the block count
  `FBFL_ASSERT_IMPL(a_alloc_bound, clk, rst, 1'b1, alloc <= count, "allocated count too high")
  // the free list head is a managed block or null
  `FBFL_ASSERT_IMPL(a_head_valid, clk, rst, 1'b1, head < count || head == NULL_LINK, "bad head")
  // the sweep stays inside the managed blocks
  `FBFL_ASSERT_IMPL(a_sweep_bound, clk, rst, state == S_SWEEP, ptr < count, "sweep overrun")

endmodule

`default_nettype wire
